### rtl/bounded_array_list_engine_defines.svh
// Assertion macros used by the list engine datapath.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define BALE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define BALE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bale_pkg.sv
// Shared types and codes for the bounded array list engine.
`default_nettype none
package bale_pkg;

	localparam int IDX_W   = 6;
	localparam int DAY_W   = 5;
	localparam int MON_W   = 4;
	localparam int YEAR_W  = 16;
	localparam int CAP_W   = 7;
	localparam int MODE_W  = 3;
	localparam int ST_W    = 2;
	localparam int FILL_W  = 7;
	localparam int WORD_W  = DAY_W + MON_W + YEAR_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int RSEL_W  = 3;

	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_INDEX = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// word index of a register: paddr[2]
	localparam logic [0:0] REG_CAPACITY = 1'd0;

	// RAM read address select
	localparam logic [RSEL_W-1:0] RD_INDEX   = 3'd0;
	localparam logic [RSEL_W-1:0] RD_PTR_DN  = 3'd1;
	localparam logic [RSEL_W-1:0] RD_PTR_UP  = 3'd2;
	localparam logic [RSEL_W-1:0] RD_NEXT_DN = 3'd3;
	localparam logic [RSEL_W-1:0] RD_NEXT_UP = 3'd4;

	// RAM write source
	localparam logic WR_SHIFT = 1'b0;
	localparam logic WR_WORD  = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  index;
		logic [DAY_W-1:0]  entry_day;
		logic [MON_W-1:0]  entry_month;
		logic [YEAR_W-1:0] entry_year;
	} in_item_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DAY_W-1:0]  read_day;
		logic [MON_W-1:0]  read_month;
		logic [YEAR_W-1:0] read_year;
		logic [FILL_W-1:0] fill_count;
	} out_item_t;

	typedef struct packed {
		logic              take;
		logic              k_from_cnt;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              ptr_ld_cnt;
		logic              ptr_ld_idx;
		logic              ptr_inc;
		logic              ptr_dec;
		logic              rd_en;
		logic [RSEL_W-1:0] rd_sel;
		logic              wr_en;
		logic              wr_sel;
		logic [ST_W-1:0]   res_status;
		logic              res_get;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] in_mode;
		logic              full;
		logic              idx_bad;
		logic              has_shift;
		logic              up_more;
		logic              dn_more;
		logic              out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/bale_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bale_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/bale_regs.sv
// APB configuration register: list capacity.
`default_nettype none
module bale_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bale_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bale_pkg::PDATA_W-1:0]  pwdata,
	output logic      [bale_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output logic      [bale_pkg::CAP_W-1:0]    capacity
);
	import bale_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             hit;

	assign hit    = (paddr[PADDR_W-1:2] == REG_CAPACITY);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = PDATA_W'(capacity_q);
		end
	end

	assign capacity = capacity_q;

endmodule
`default_nettype wire

### rtl/bale_dp.sv
// Datapath: entry RAM, fill count, shift pointer, result and output registers.
`default_nettype none
`include "bounded_array_list_engine_defines.svh"
module bale_dp #(
	parameter int DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bale_pkg::in_item_t        in_item,
	input  wire logic [bale_pkg::CAP_W-1:0] capacity,
	input  wire bale_pkg::dp_cmd_t         cmd,
	output bale_pkg::dp_stat_t             stat,
	output bale_pkg::out_item_t            out_item,
	output logic                           out_valid,
	input  wire logic                      out_ready
);
	import bale_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     k_q;
	logic [WORD_W-1:0] word_q;
	logic [ST_W-1:0]   res_status_q;
	logic [WORD_W-1:0] res_word_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     cap_x;
	logic [XW-1:0]     ptr_x;
	logic [XW-1:0]     k_x;
	logic [XW-1:0]     rd_addr_x;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;
	logic              out_free;

	assign cnt_x = XW'(count_q);
	assign idx_x = XW'(in_item.index);
	assign cap_x = XW'(capacity);
	assign ptr_x = XW'(ptr_q);
	assign k_x   = XW'(k_q);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat          = '0;
		stat.in_mode  = in_item.mode;
		stat.full     = (cnt_x >= cap_x) || (cnt_x >= DEPTH_X);
		stat.up_more  = ptr_x > (k_x + XW'(1));
		stat.dn_more  = (ptr_x + XW'(1)) < cnt_x;
		stat.out_free = out_free;
		if (in_item.mode == MODE_INSERT) begin
			stat.idx_bad   = idx_x > cnt_x;
			stat.has_shift = cnt_x > idx_x;
		end else if (in_item.mode == MODE_REMOVE) begin
			stat.idx_bad   = idx_x >= cnt_x;
			stat.has_shift = (idx_x + XW'(1)) < cnt_x;
		end else begin
			stat.idx_bad   = idx_x >= cnt_x;
			stat.has_shift = 1'b0;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_INDEX:   rd_addr_x = idx_x;
			RD_PTR_DN:  rd_addr_x = ptr_x - XW'(1);
			RD_PTR_UP:  rd_addr_x = ptr_x + XW'(1);
			RD_NEXT_DN: rd_addr_x = ptr_x - XW'(2);
			RD_NEXT_UP: rd_addr_x = ptr_x + XW'(2);
			default:    rd_addr_x = ptr_x;
		endcase
	end

	assign raddr = rd_addr_x[AW-1:0];
	assign waddr = (cmd.wr_sel == WR_SHIFT) ? ptr_q[AW-1:0] : k_q[AW-1:0];
	assign wdata = (cmd.wr_sel == WR_SHIFT) ? rdata : word_q;

	bale_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_ld_cnt) begin
			ptr_q <= count_q;
		end else if (cmd.ptr_ld_idx) begin
			ptr_q <= CW'(idx_x);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - CW'(1);
		end
		if (cmd.take) begin
			k_q          <= cmd.k_from_cnt ? count_q : CW'(idx_x);
			word_q       <= {in_item.entry_year, in_item.entry_month, in_item.entry_day};
			res_status_q <= cmd.res_status;
			res_word_q   <= '0;
		end else if (cmd.res_get) begin
			res_word_q <= rdata;
		end
		if (cmd.out_load) begin
			out_q.status     <= res_status_q;
			out_q.read_day   <= res_word_q[DAY_W-1:0];
			out_q.read_month <= res_word_q[DAY_W+MON_W-1:DAY_W];
			out_q.read_year  <= res_word_q[WORD_W-1:DAY_W+MON_W];
			out_q.fill_count <= cnt_x[FILL_W-1:0];
		end
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

	`BALE_ASSERT_IMP(a_out_load_free, cmd.out_load, out_free, "result loaded over a waiting item")
	`BALE_ASSERT_NXT(a_count_only_on_take, !cmd.take, $stable(count_q), "fill count moved mid-item")
	`BALE_ASSERT_IMP(a_get_after_read, cmd.res_get, $past(cmd.rd_en), "read data captured without a read")
	`BALE_ASSERT_IMP(a_count_in_range, 1'b1, cnt_x <= DEPTH_X, "fill count above store depth")

endmodule
`default_nettype wire

### rtl/bale_ctrl.sv
// Controller: request decode and shift sequencer.
`default_nettype none
module bale_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bale_pkg::dp_stat_t stat,
	output bale_pkg::dp_cmd_t       cmd
);
	import bale_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_GET   = 3'd1;
	localparam logic [2:0] S_UP_RD = 3'd2;
	localparam logic [2:0] S_UP    = 3'd3;
	localparam logic [2:0] S_DN_RD = 3'd4;
	localparam logic [2:0] S_DN    = 3'd5;
	localparam logic [2:0] S_WRITE = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_RESP;
					case (stat.in_mode)
						MODE_APPEND: begin
							if (stat.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.k_from_cnt = 1'b1;
								cmd.cnt_inc    = 1'b1;
								state_d        = S_WRITE;
							end
						end
						MODE_INSERT: begin
							if (stat.full) begin
								cmd.res_status = ST_FULL;
							end else if (stat.idx_bad) begin
								cmd.res_status = ST_INDEX;
							end else begin
								cmd.cnt_inc    = 1'b1;
								cmd.ptr_ld_cnt = 1'b1;
								state_d        = stat.has_shift ? S_UP_RD : S_WRITE;
							end
						end
						MODE_REMOVE: begin
							if (stat.idx_bad) begin
								cmd.res_status = ST_INDEX;
							end else begin
								cmd.cnt_dec    = 1'b1;
								cmd.ptr_ld_idx = 1'b1;
								state_d        = stat.has_shift ? S_DN_RD : S_RESP;
							end
						end
						MODE_GET: begin
							if (stat.idx_bad) begin
								cmd.res_status = ST_INDEX;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_INDEX;
								state_d    = S_GET;
							end
						end
						MODE_SET: begin
							if (stat.idx_bad) begin
								cmd.res_status = ST_INDEX;
							end else begin
								state_d = S_WRITE;
							end
						end
						default: begin
							cmd.res_status = ST_OK;
						end
					endcase
				end
			end
			S_GET: begin
				cmd.res_get = 1'b1;
				state_d     = S_RESP;
			end
			S_UP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR_DN;
				state_d    = S_UP;
			end
			S_UP: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_dec = 1'b1;
				if (stat.up_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT_DN;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR_UP;
				state_d    = S_DN;
			end
			S_DN: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_inc = 1'b1;
				if (stat.dn_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT_UP;
				end else begin
					state_d = S_RESP;
				end
			end
			S_WRITE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_WORD;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### rtl/bounded_array_list_engine.sv
// Top level: bounded array list of date entries.
// Sequential; errors, unknown modes and remove of the last entry go straight to the result load;
// append, set and insert at the end write the entry first, get reads it; inserts and removes that
// move m entries shift them first. Next item accepted in the cycle after the result loads; a
// result left waiting stalls the next one at its load step. One entry moves per cycle.
// Reset clears fill count to zero and capacity to 64; the store is not cleared.
`default_nettype none
module bounded_array_list_engine #(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire bale_pkg::in_item_t           req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output bale_pkg::out_item_t               rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bale_pkg::PADDR_W-1:0] paddr,
	input  wire logic [bale_pkg::PDATA_W-1:0] pwdata,
	output logic      [bale_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import bale_pkg::*;

	logic [CAP_W-1:0] capacity;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	bale_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	bale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_valid),
		.in_ready (req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bale_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (req),
		.capacity  (capacity),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (rsp),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready)
	);

endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for the bounded array list engine: directed plan, then random phases.
`default_nettype none
module tb;
	import bale_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 152;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
	} date_t;

	typedef struct packed {
		logic             is_cfg;
		logic [CAP_W-1:0] cap;
		logic             typed;
		in_item_t         item;
		out_item_t        want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	in_item_t            req;
	logic                rsp_valid;
	logic                rsp_ready;
	out_item_t           rsp;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	date_t            list_words [LIST_DEPTH];
	int               list_len;
	logic [CAP_W-1:0] cap_reg;
	out_item_t        owed_answers [$];
	plan_row_t        plan [$];
	bit               failed;
	bit               calm;
	bit               hold_rsp;
	int               quiet_cycles = 0;

	bounded_array_list_engine #(.DEPTH(LIST_DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// list behavior after one request; updates the shadow list
	function automatic out_item_t list_op_result(in_item_t it);
		out_item_t o;
		date_t     w;
		int        lim;
		int        k;
		int        i;
		o = '0;
		w.year = it.entry_year;
		w.month = it.entry_month;
		w.day = it.entry_day;
		lim = (int'(cap_reg) < LIST_DEPTH) ? int'(cap_reg) : LIST_DEPTH;
		k = int'(it.index);
		case (it.mode)
			MODE_APPEND, MODE_INSERT: begin
				if (list_len >= lim) begin
					o.status = ST_FULL;
				end else if (it.mode == MODE_INSERT && k > list_len) begin
					o.status = ST_INDEX;
				end else begin
					if (it.mode == MODE_APPEND)
						k = list_len;
					for (i = list_len; i > k; i--)
						list_words[i] = list_words[i-1];
					list_words[k] = w;
					list_len++;
				end
			end
			MODE_REMOVE, MODE_GET, MODE_SET: begin
				if (k >= list_len) begin
					o.status = ST_INDEX;
				end else if (it.mode == MODE_REMOVE) begin
					list_len--;
					for (i = k; i < list_len; i++)
						list_words[i] = list_words[i+1];
				end else if (it.mode == MODE_GET) begin
					o.read_day = list_words[k].day;
					o.read_month = list_words[k].month;
					o.read_year = list_words[k].year;
				end else begin
					list_words[k] = w;
				end
			end
			default: ;
		endcase
		o.fill_count = FILL_W'(list_len);
		return o;
	endfunction

	function automatic in_item_t draw_request(int grow_pct, int shrink_pct);
		in_item_t it;
		int       r;
		int       n;
		n = list_len;
		it.entry_day = DAY_W'($urandom_range(0, 31));
		it.entry_month = MON_W'($urandom_range(0, 15));
		it.entry_year = YEAR_W'($urandom_range(0, 65535));
		it.index = IDX_W'($urandom_range(0, 63));
		r = $urandom_range(0, 99);
		if (r < 3) begin
			it.mode = MODE_W'($urandom_range(5, 7));
		end else if (r < 10) begin
			it.mode = MODE_W'($urandom_range(0, 4));
		end else begin
			r = $urandom_range(0, 99);
			if (r < grow_pct || n == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					it.mode = MODE_APPEND;
				end else begin
					it.mode = MODE_INSERT;
					it.index = IDX_W'($urandom_range(0, (n > 63) ? 63 : n));
				end
			end else begin
				if (r < grow_pct + shrink_pct)
					it.mode = MODE_REMOVE;
				else if ($urandom_range(0, 1) == 0)
					it.mode = MODE_GET;
				else
					it.mode = MODE_SET;
				it.index = IDX_W'($urandom_range(0, n - 1));
			end
		end
		return it;
	endfunction

	function automatic plan_row_t op(logic [MODE_W-1:0] mode, int idx, int d, int m, int y);
		plan_row_t r;
		r = '0;
		r.item.mode = mode;
		r.item.index = IDX_W'(idx);
		r.item.entry_day = DAY_W'(d);
		r.item.entry_month = MON_W'(m);
		r.item.entry_year = YEAR_W'(y);
		return r;
	endfunction

	function automatic plan_row_t op_exp(logic [MODE_W-1:0] mode, int idx, int d, int m, int y,
			logic [ST_W-1:0] st, int rd, int rm, int ry, int fill);
		plan_row_t r;
		r = op(mode, idx, d, m, y);
		r.typed = 1'b1;
		r.want.status = st;
		r.want.read_day = DAY_W'(rd);
		r.want.read_month = MON_W'(rm);
		r.want.read_year = YEAR_W'(ry);
		r.want.fill_count = FILL_W'(fill);
		return r;
	endfunction

	function automatic plan_row_t cap_row(int v);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cap = CAP_W'(v);
		return r;
	endfunction

	function automatic void add_row(plan_row_t r);
		plan = {plan, r};
	endfunction

	// offer one item; predict at the accepting edge
	task automatic offer(in_item_t it, logic typed, out_item_t want);
		int        gap;
		out_item_t got;
		out_item_t ans;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		got = list_op_result(it);
		ans = typed ? want : got;
		owed_answers = {owed_answers, ans};
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (owed_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// optional write, then read back
	task automatic apb_capacity(bit do_write, logic [CAP_W-1:0] v);
		if (do_write) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= CAP_ADDR;
			pwdata <= PDATA_W'(v);
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			cap_reg = v;
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cmp_field("capacity", 32'(cap_reg), 32'(prdata[CAP_W-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// result side
	initial begin
		int        wait_n;
		out_item_t want;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				wait_n = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end else begin
				wait_n = calm ? 0 : $urandom_range(0, 13);
			end
			if (wait_n > 0) begin
				rsp_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (rsp_valid !== 1'b1) @(posedge clk);
			if (owed_answers.size() == 0) begin
				$error("result with nothing expected: status %0d fill %0d",
					rsp.status, rsp.fill_count);
				failed = 1'b1;
			end else begin
				want = owed_answers.pop_front();
				cmp_field("status", 32'(want.status), 32'(rsp.status));
				cmp_field("read_day", 32'(want.read_day), 32'(rsp.read_day));
				cmp_field("read_month", 32'(want.read_month), 32'(rsp.read_month));
				cmp_field("read_year", 32'(want.read_year), 32'(rsp.read_year));
				cmp_field("fill_count", 32'(want.fill_count), 32'(rsp.fill_count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no progress for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int caps [PHASES];
		int grow [PHASES];
		int shrink [PHASES];
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		failed = 1'b0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		list_len = 0;
		cap_reg = CAP_RESET;

		add_row(op_exp(MODE_GET, 0, 0, 0, 0, ST_INDEX, 0, 0, 0, 0));
		add_row(op_exp(MODE_REMOVE, 0, 0, 0, 0, ST_INDEX, 0, 0, 0, 0));
		add_row(op_exp(MODE_SET, 0, 9, 9, 9, ST_INDEX, 0, 0, 0, 0));
		add_row(op_exp(MODE_INSERT, 1, 1, 1, 1, ST_INDEX, 0, 0, 0, 0));
		add_row(op_exp(MODE_INSERT, 0, 31, 15, 65535, ST_OK, 0, 0, 0, 1));
		add_row(op_exp(MODE_APPEND, 63, 0, 0, 0, ST_OK, 0, 0, 0, 2));
		add_row(op_exp(MODE_GET, 0, 0, 0, 0, ST_OK, 31, 15, 65535, 2));
		add_row(op_exp(MODE_GET, 1, 31, 15, 65535, ST_OK, 0, 0, 0, 2));
		add_row(op(MODE_INSERT, 1, 5, 3, 2024));
		add_row(op(MODE_GET, 2, 0, 0, 0));
		add_row(op(MODE_SET, 2, 21, 10, 43690));
		add_row(op_exp(3'd7, 63, 31, 15, 65535, ST_OK, 0, 0, 0, 3));
		add_row(op(3'd5, 0, 1, 2, 3));
		add_row(op(3'd6, 2, 4, 5, 6));
		add_row(op_exp(MODE_GET, 63, 0, 0, 0, ST_INDEX, 0, 0, 0, 3));
		add_row(op(MODE_REMOVE, 0, 0, 0, 0));
		add_row(op(MODE_GET, 0, 0, 0, 0));
		// capacity below the fill count
		add_row(cap_row(1));
		add_row(op_exp(MODE_APPEND, 0, 7, 7, 7, ST_FULL, 0, 0, 0, 2));
		add_row(op_exp(MODE_INSERT, 63, 7, 7, 7, ST_FULL, 0, 0, 0, 2));
		add_row(op(MODE_REMOVE, 1, 0, 0, 0));
		add_row(op_exp(MODE_APPEND, 0, 7, 7, 7, ST_FULL, 0, 0, 0, 1));
		add_row(cap_row(0));
		add_row(op(MODE_REMOVE, 0, 0, 0, 0));
		add_row(op_exp(MODE_APPEND, 0, 7, 7, 7, ST_FULL, 0, 0, 0, 0));
		add_row(cap_row(127));
		add_row(op(MODE_APPEND, 0, 17, 6, 1999));
		add_row(op(MODE_SET, 0, 30, 12, 21845));
		add_row(op(MODE_GET, 0, 0, 0, 0));

		caps = '{64, 127, 3, 0, 1, 127, 0, 64, 10, 40};
		caps[6] = $urandom_range(0, 127);
		grow = '{60, 75, 35, 40, 50, 55, 45, 65, 45, 50};
		shrink = '{20, 10, 35, 40, 30, 25, 35, 20, 35, 30};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_capacity(1'b0, '0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				apb_capacity(1'b1, plan[i].cap);
			end else begin
				offer(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			apb_capacity(1'b1, CAP_W'(caps[p]));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (p == 1 && n == 40)
					hold_rsp = 1'b1;
				offer(draw_request(grow[p], shrink[p]), 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		while (owed_answers.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/bale_pkg.sv
rtl/bale_ram.sv
rtl/bale_regs.sv
rtl/bale_dp.sv
rtl/bale_ctrl.sv
rtl/bounded_array_list_engine.sv
sim/tb.sv
